[hw/rtl/rsh_pkg.sv]
// Shared types and constants for the radio squelch hysteresis block.
// No dependencies; every other file in hw/rtl imports this package.
package rsh_pkg;

    // Configuration register indexes, in the order of the register map.
    typedef enum logic [2:0] {
        REG_NOISE_FLOOR      = 3'd0,
        REG_NOISE_THRESHOLD  = 3'd1,
        REG_SQUELCH_LEVEL    = 3'd2,
        REG_HIGH_NOISE_LIMIT = 3'd3,
        REG_TAIL_ELIM_ENABLE = 3'd4,
        REG_RX_SUBTONE_CODE  = 3'd5
    } cfg_reg_t;

    localparam int unsigned CFG_INDEX_W = 3;
    localparam int unsigned CFG_DATA_W  = 16;

    // Register reset values.
    localparam logic [8:0]  NOISE_FLOOR_RST      = 9'd62;
    localparam logic [7:0]  NOISE_THRESHOLD_RST  = 8'd0;
    localparam logic [3:0]  SQUELCH_LEVEL_RST    = 4'd0;
    localparam logic [7:0]  HIGH_NOISE_LIMIT_RST = 8'd64;
    localparam logic        TAIL_ELIM_ENABLE_RST = 1'b0;
    localparam logic [15:0] RX_SUBTONE_CODE_RST  = 16'd0;

    // Hysteresis offsets, all applied in 8-bit wrapping arithmetic.
    localparam logic [7:0]  NOISE_HYST_UP     = 8'd8;
    localparam logic [7:0]  NOISE_HYST_DOWN   = 8'hF8;
    localparam logic [7:0]  LEVEL_HYST_DOWN   = 8'hFE;
    localparam logic [7:0]  LEVEL_HYST_UP     = 8'd2;
    localparam logic [7:0]  LEVEL_STEP        = 8'd12;
    // Minus one S-level step, so that level 1 maps to a threshold of zero.
    localparam logic [7:0]  LEVEL_BASE        = 8'd244;
    localparam logic [7:0]  LEVEL_SAT         = 8'd255;
    localparam logic [2:0]  TRIP_LIMIT        = 3'd3;
    localparam logic [3:0]  SQUELCH_ALWAYS    = 4'd0;
    localparam logic [3:0]  SQUELCH_NOISE     = 4'd1;
    localparam logic [15:0] SUBTONE_NONE      = 16'd0;
    localparam logic [15:0] SUBTONE_LATCHING  = 16'd1050;

    typedef struct packed {
        logic [8:0]  noise_floor;
        logic [7:0]  noise_threshold;
        logic [3:0]  squelch_level;
        logic [7:0]  high_noise_limit;
        logic        tail_elim_enable;
        logic [15:0] rx_subtone_code;
    } cfg_t;

    typedef struct packed {
        logic [8:0] rssi_raw;
        logic [7:0] excess_noise;
        logic       subtone_heard;
        logic       open_pause;
        logic       tail_tone_heard;
        logic       tail_timer_running;
        logic       data_mode_active;
        logic       vfo_is_active;
        logic       monitor_override;
    } meas_t;

    typedef struct packed {
        logic signal_present;
        logic squelch_open;
        logic subtone_bypass;
    } result_t;

endpackage

[hw/rtl/rsh_if.sv]
// Valid/ready channel interfaces for measurement words and result words.
// Depends on rsh_pkg for the payload types.
interface rsh_meas_if
    import rsh_pkg::*;
();
    logic  valid;
    logic  ready;
    meas_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface rsh_result_if
    import rsh_pkg::*;
();
    logic    valid;
    logic    ready;
    result_t data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

[hw/rtl/rsh_cfg_regs.sv]
// Configuration register file for the squelch block, written through a plain port.
// Depends on rsh_pkg for the register map and the cfg_t struct.
module rsh_cfg_regs
    import rsh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data,
    output cfg_t                   cfg
);

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            case (cfg_reg_t'(wr_index))
                REG_NOISE_FLOOR:      cfg_next.noise_floor      = wr_data[8:0];
                REG_NOISE_THRESHOLD:  cfg_next.noise_threshold  = wr_data[7:0];
                REG_SQUELCH_LEVEL:    cfg_next.squelch_level    = wr_data[3:0];
                REG_HIGH_NOISE_LIMIT: cfg_next.high_noise_limit = wr_data[7:0];
                REG_TAIL_ELIM_ENABLE: cfg_next.tail_elim_enable = wr_data[0];
                REG_RX_SUBTONE_CODE:  cfg_next.rx_subtone_code  = wr_data[15:0];
                default:              cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.noise_floor      <= NOISE_FLOOR_RST;
            cfg_reg.noise_threshold  <= NOISE_THRESHOLD_RST;
            cfg_reg.squelch_level    <= SQUELCH_LEVEL_RST;
            cfg_reg.high_noise_limit <= HIGH_NOISE_LIMIT_RST;
            cfg_reg.tail_elim_enable <= TAIL_ELIM_ENABLE_RST;
            cfg_reg.rx_subtone_code  <= RX_SUBTONE_CODE_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

[hw/rtl/rsh_decide.sv]
// Carrier hysteresis, noise trip counter and squelch gate decision.
// Depends on rsh_pkg; holds the per-channel state, updated when a word advances.
module rsh_decide
    import rsh_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_t    cfg,
    input  meas_t   meas,
    input  logic    advance,
    output result_t res
);

    logic       carrier_reg;
    logic       carrier_next;
    logic [2:0] trip_count_reg;
    logic [2:0] trip_count_next;
    logic       tone_reg;
    logic       tone_next;
    logic       bypass_reg;
    logic       bypass_next;

    logic [9:0] diff;
    logic [7:0] level_sig;
    logic       carrier_mid;
    logic [7:0] target_noise;
    logic [7:0] target_lvl;
    logic       trig_lvl;
    logic       trig_noise;
    logic       open;

    always_comb
    begin
        carrier_next    = carrier_reg;
        trip_count_next = trip_count_reg;
        tone_next       = tone_reg;
        bypass_next     = bypass_reg;
        carrier_mid     = carrier_reg;
        open            = 1'b1;

        // Level above the noise floor, clamped to one byte.
        diff = {1'b0, meas.rssi_raw} - {1'b0, cfg.noise_floor};
        if (diff[9])
            level_sig = 8'd0;
        else if (diff[8])
            level_sig = LEVEL_SAT;
        else
            level_sig = diff[7:0];

        target_noise = 8'd0;
        target_lvl   = 8'd0;
        trig_lvl     = 1'b0;
        trig_noise   = 1'b0;

        if (meas.open_pause)
        begin
            carrier_next = 1'b1;
            open         = 1'b1;
        end
        else
        begin
            // Sustained high noise without subtone drops the carrier on the fifth tick.
            if ((meas.excess_noise > cfg.high_noise_limit) && !tone_reg)
            begin
                if (trip_count_reg > TRIP_LIMIT)
                begin
                    carrier_mid     = 1'b0;
                    trip_count_next = 3'd0;
                end
                else
                begin
                    trip_count_next = trip_count_reg + 3'd1;
                end
            end
            else
            begin
                trip_count_next = 3'd0;
            end

            tone_next = meas.subtone_heard;

            target_noise = cfg.noise_threshold +
                           (carrier_mid ? NOISE_HYST_UP : NOISE_HYST_DOWN);
            target_lvl = 8'({4'd0, cfg.squelch_level} * LEVEL_STEP) + LEVEL_BASE +
                         (carrier_mid ? LEVEL_HYST_DOWN : LEVEL_HYST_UP);
            if (carrier_mid)
            begin
                trig_lvl   = level_sig < target_lvl;
                trig_noise = meas.excess_noise > target_noise;
            end
            else
            begin
                trig_lvl   = level_sig > target_lvl;
                trig_noise = meas.excess_noise < target_noise;
            end

            carrier_next = carrier_mid;
            if (trig_noise && ((cfg.squelch_level == SQUELCH_NOISE) || trig_lvl))
                carrier_next = !carrier_mid;

            if ((cfg.tail_elim_enable && meas.tail_tone_heard) || meas.tail_timer_running)
            begin
                open = 1'b0;
            end
            else if (!meas.data_mode_active && meas.vfo_is_active &&
                     ((cfg.squelch_level == SQUELCH_ALWAYS) || meas.monitor_override))
            begin
                open = 1'b1;
            end
            else if ((cfg.rx_subtone_code != SUBTONE_NONE) && !bypass_reg)
            begin
                open = meas.subtone_heard;
                if (meas.subtone_heard && (cfg.rx_subtone_code == SUBTONE_LATCHING))
                    bypass_next = 1'b1;
            end
            else
            begin
                open = carrier_next;
            end

            if (!carrier_next)
                bypass_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            carrier_reg    <= 1'b0;
            trip_count_reg <= 3'd0;
            tone_reg       <= 1'b0;
            bypass_reg     <= 1'b0;
        end
        else if (advance)
        begin
            carrier_reg    <= carrier_next;
            trip_count_reg <= trip_count_next;
            tone_reg       <= tone_next;
            bypass_reg     <= bypass_next;
        end
    end

    assign res.signal_present = carrier_next;
    assign res.squelch_open   = open;
    assign res.subtone_bypass = bypass_next;

    // The trip counter wraps back to zero on its fifth count.
    assert property (@(posedge clk) disable iff (!rst_n) trip_count_reg <= 3'd4)
        else $error("noise trip counter exceeded four");

    // The subtone bypass is only ever held while a carrier is present.
    assert property (@(posedge clk) disable iff (!rst_n) bypass_reg |-> carrier_reg)
        else $error("subtone bypass set without carrier");

    // An open pause word always leaves the carrier flag set.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (advance && meas.open_pause) |=> carrier_reg)
        else $error("carrier not set after open pause");

endmodule

[hw/rtl/radio_squelch_hysteresis_core.sv]
// Top level of the radio squelch hysteresis block.
// Depends on rsh_pkg, rsh_if, rsh_cfg_regs and rsh_decide.
//
// Measurement words arrive on the meas channel (valid/ready), one per receiver
// tick, with the raw RSSI, the excess-noise reading and the qualifier flags. For
// every accepted word exactly one result word leaves on the result channel with
// the carrier flag, the squelch-open decision and the subtone bypass flag. The
// configuration registers are written through wr_en / wr_index / wr_data and
// take effect on the next word; write them only while no word is in flight.
// A word is captured in an input register at the accepting edge, evaluated by
// the decision logic in the next cycle and loaded into the result register when
// the decision stage advances, which a stalled result register holds off. One
// word is taken every cycle while the receiver keeps ready high; the carrier
// state is updated as each word passes the decision stage, so consecutive words
// see each other's effect with no bubble.
// Reset loads the register defaults and clears the carrier, trip counter, tone
// and bypass state and both stage valids. When the receiver holds ready low, the
// result register keeps its word, the input register keeps the next one, and
// meas.ready drops once both are full.
module radio_squelch_hysteresis_core
    import rsh_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    rsh_meas_if.sink               meas,
    rsh_result_if.source           result,
    input  logic                   wr_en,
    input  logic [CFG_INDEX_W-1:0] wr_index,
    input  logic [CFG_DATA_W-1:0]  wr_data
);

    cfg_t    cfg;
    meas_t   meas_reg;
    logic    meas_valid_reg;
    logic    meas_valid_next;
    result_t res;
    result_t result_reg;
    logic    result_valid_reg;
    logic    result_valid_next;
    logic    advance;
    logic    take;

    rsh_cfg_regs u_cfg_regs (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg)
    );

    // The decision stage moves a word on whenever the result register is
    // free or being emptied this cycle; the state advances with it.
    assign advance    = meas_valid_reg && (!result_valid_reg || result.ready);
    assign meas.ready = !meas_valid_reg || advance;
    assign take       = meas.valid && meas.ready;

    rsh_decide u_decide (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (cfg),
        .meas    (meas_reg),
        .advance (advance),
        .res     (res)
    );

    always_comb
    begin
        meas_valid_next = meas_valid_reg;
        if (take)
            meas_valid_next = 1'b1;
        else if (advance)
            meas_valid_next = 1'b0;

        result_valid_next = result_valid_reg;
        if (advance)
            result_valid_next = 1'b1;
        else if (result.ready)
            result_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            meas_valid_reg   <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            meas_valid_reg   <= meas_valid_next;
            result_valid_reg <= result_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        if (take)
            meas_reg <= meas.data;
        if (advance)
            result_reg <= res;
    end

    assign result.valid = result_valid_reg;
    assign result.data  = result_reg;

    // A word that leaves the decision stage shows up as a valid result.
    assert property (@(posedge clk) disable iff (!rst_n) advance |=> result_valid_reg)
        else $error("advanced word did not reach the result register");

    // A stalled result is not overwritten by the decision stage.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (result_valid_reg && !result.ready) |-> !advance)
        else $error("decision stage advanced into a stalled result");

    // The input register never drops a word it has not passed on.
    assert property (@(posedge clk) disable iff (!rst_n)
                     (meas_valid_reg && !advance) |=> meas_valid_reg)
        else $error("input word lost while waiting");

endmodule
